>>> hw/rtl/bcb_pkg.sv
// bcb_pkg: shared types and constants for the block coverage bitmap.
// Holds opcodes, status codes, register indexes, field widths and the
// sequencer state type. No dependencies.
package bcb_pkg;

  // Default geometry of the bitmap
  localparam int MAP_WORDS_DEF = 1024;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int BLK_W    = 15;
  localparam int CNT_W    = 13;
  localparam int SW_W     = 10;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 16;
  localparam int CFG_A_W  = 2;
  localparam int IN_D_W   = 40;
  localparam int IN_U_W   = 2;
  localparam int OUT_D_W  = 48;

  // Internal widths: block positions and word indexes during a walk
  localparam int POS_W    = 18;
  localparam int IDX_W    = 17;
  // Reciprocal shift for the block to word split
  localparam int QSH      = 16;

  localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic [CFG_A_W-1:0] REG_STOP_AT_USED = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SCAN_LIMIT   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_BLOCK    = 2'd2;

  localparam logic [CFG_W-1:0] SCAN_LIMIT_RST = 16'd32768;
  localparam logic [CFG_W-1:0] MAX_BLOCK_RST  = 16'd32768;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SPLIT,
    ST_ISSUE,
    ST_EXEC,
    ST_DONE
  } bcb_state_t;

endpackage

>>> hw/rtl/block_coverage_bitmap.sv
// block_coverage_bitmap: visited-block bitmap with query, mark-run and
// find-first-free operations over a single-port-write synchronous memory.
// Depends on bcb_pkg.

// One bit per block records whether it has been visited; the bitmap is
// MAP_WORDS words of WORD_BITS bits in one synchronous memory (one write and
// one registered read per cycle). After reset the block sweeps the memory to
// zero, one word a cycle, through all MAP_WORDS words; in_tready stays low
// during that sweep, configuration writes are taken as ever. Items are
// handled one at a time by a read-modify-write sequencer. A query or a mark
// first splits its block index into word and bit offset. A query then reads
// one word; a mark reads each word it touches, then modifies and writes it
// back. A find-free reads word after word until one has a free bit or the
// scan ends at the limit or the map end. The word loop through the memory
// read port sets the rate. A finished result waits in the output register,
// and the next item is taken while it waits.
// opcode 0 query, 1 mark, 2 find-free; opcode 3 answers status 0 and does
// nothing. Status 0 ok, 1 no free block, 2 word index beyond the bitmap.
module block_coverage_bitmap
  import bcb_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_tvalid,
  output logic                in_tready,
  // block_index[14:0], block_count[27:15], start_word[37:28], zero fill
  input  logic [IN_D_W-1:0]   in_tdata,
  // opcode[1:0]
  input  logic [IN_U_W-1:0]   in_tuser,
  // result items
  output logic                out_tvalid,
  input  logic                out_tready,
  // status[1:0], is_free[2], blocks_marked[15:3], found_block[30:16],
  // found_word[40:31], zero fill
  output logic [OUT_D_W-1:0]  out_tdata,
  // configuration writes
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int RECIP  = (1 << QSH) / WORD_BITS;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PROD_W = BLK_W + RW;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic             stop_at_used_r;
  logic [CFG_W-1:0] scan_limit_r;
  logic [CFG_W-1:0] max_block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_at_used_r <= 1'b0;
      scan_limit_r   <= SCAN_LIMIT_RST;
      max_block_r    <= MAX_BLOCK_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STOP_AT_USED: stop_at_used_r <= cfg_wdata[0];
        REG_SCAN_LIMIT:   scan_limit_r   <= cfg_wdata;
        REG_MAX_BLOCK:    max_block_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Bitmap memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= map_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  bcb_state_t          state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic                is_free_r, is_free_nxt;
  logic [CNT_W-1:0]    marked_r, marked_nxt;
  logic [BLK_W-1:0]    fblock_r, fblock_nxt;
  logic [SW_W-1:0]     fword_r, fword_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_D_W-1:0]  out_data_r, out_data_nxt;

  // Word-level helpers on the read data
  logic [BW-1:0]        first_zero;
  logic                 word_full;
  logic [CNT_W-1:0]     room;
  logic [CNT_W-1:0]     take;
  logic [WORD_BITS-1:0] run_mask;
  logic [PROD_W-1:0]    prod;
  logic [POS_W-1:0]     rem;
  logic [POS_W-1:0]     cand;
  logic [POS_W-1:0]     word_pos;

  always_comb begin
    first_zero = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (!rdata_r[k]) begin
        first_zero = BW'(k);
      end
    end
  end

  assign word_full = (rdata_r == {WORD_BITS{1'b1}});
  assign room      = CNT_W'(WORD_BITS) - CNT_W'(bit_r);
  assign take      = (cnt_r < room) ? cnt_r : room;

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      run_mask[k] = (CNT_W'(k) >= CNT_W'(bit_r)) &&
                    (CNT_W'(k) < (CNT_W'(bit_r) + take));
    end
  end

  assign prod     = PROD_W'(blk_r) * PROD_W'(RECIP);
  assign rem      = POS_W'(blk_r) - POS_W'(idx_r) * POS_W'(WORD_BITS);
  assign cand     = pos_r + POS_W'(first_zero);
  assign word_pos = POS_W'(in_tdata[37:28]) * POS_W'(WORD_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    blk_r      <= blk_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    bit_r      <= bit_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    is_free_r  <= is_free_nxt;
    marked_r   <= marked_nxt;
    fblock_r   <= fblock_nxt;
    fword_r    <= fword_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    bit_nxt        = bit_r;
    pos_nxt        = pos_r;
    status_nxt     = status_r;
    is_free_nxt    = is_free_r;
    marked_nxt     = marked_r;
    fblock_nxt     = fblock_r;
    fword_nxt      = fword_r;
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = rdata_r | run_mask;
    mem_raddr      = idx_r[AW-1:0];

    case (state_r)
      ST_CLEAR: begin
        // sweep the bitmap to zero after reset
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          blk_nxt     = in_tdata[14:0];
          cnt_nxt     = in_tdata[27:15];
          idx_nxt     = IDX_W'(in_tdata[37:28]);
          pos_nxt     = word_pos;
          status_nxt  = STATUS_OK;
          is_free_nxt = 1'b0;
          marked_nxt  = '0;
          fblock_nxt  = '0;
          fword_nxt   = '0;
          case (in_tuser)
            OP_QUERY, OP_MARK: state_nxt = ST_DIV;
            OP_FIND: begin
              status_nxt = STATUS_NONE;
              state_nxt  = ST_ISSUE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_DIV: begin
        // word estimate by reciprocal; may fall one short
        idx_nxt   = IDX_W'(prod >> QSH);
        state_nxt = ST_SPLIT;
      end

      ST_SPLIT: begin
        // correct the estimate and split off the bit offset
        if (rem >= POS_W'(WORD_BITS)) begin
          idx_nxt = idx_r + IDX_W'(1);
          bit_nxt = BW'(rem - POS_W'(WORD_BITS));
        end else begin
          bit_nxt = BW'(rem);
        end
        state_nxt = ST_ISSUE;
      end

      ST_ISSUE: begin
        // range checks, then present the read address
        case (op_r)
          OP_MARK: begin
            if (cnt_r == '0) begin
              state_nxt = ST_DONE;
            end else if (idx_r >= IDX_W'(MAP_WORDS)) begin
              status_nxt = STATUS_RANGE;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_EXEC;
            end
          end
          OP_FIND: begin
            if (pos_r >= POS_W'(scan_limit_r)) begin
              state_nxt = ST_DONE;
            end else if (idx_r >= IDX_W'(MAP_WORDS)) begin
              status_nxt = STATUS_RANGE;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_EXEC;
            end
          end
          default: begin
            if (idx_r >= IDX_W'(MAP_WORDS)) begin
              status_nxt = STATUS_RANGE;
              state_nxt  = ST_DONE;
            end else begin
              state_nxt = ST_EXEC;
            end
          end
        endcase
      end

      ST_EXEC: begin
        case (op_r)
          OP_MARK: begin
            if (stop_at_used_r && rdata_r[bit_r]) begin
              // halt on a block already visited; report at least one
              if (marked_r == '0) begin
                marked_nxt = CNT_W'(1);
              end
              state_nxt = ST_DONE;
            end else begin
              mem_we     = 1'b1;
              cnt_nxt    = cnt_r - take;
              marked_nxt = marked_r + take;
              idx_nxt    = idx_r + IDX_W'(1);
              bit_nxt    = '0;
              state_nxt  = (cnt_r == take) ? ST_DONE : ST_ISSUE;
            end
          end
          OP_FIND: begin
            if (!word_full) begin
              if (cand <= POS_W'(max_block_r)) begin
                status_nxt = STATUS_OK;
                fblock_nxt = cand[BLK_W-1:0];
                fword_nxt  = idx_r[SW_W-1:0];
              end
              state_nxt = ST_DONE;
            end else begin
              pos_nxt   = pos_r + POS_W'(WORD_BITS);
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = ST_ISSUE;
            end
          end
          default: begin
            is_free_nxt = !rdata_r[bit_r];
            state_nxt   = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = {7'd0, fword_r, fblock_r, marked_r, is_free_r, status_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> tb/block_coverage_bitmap_checker.sv
`timescale 1ns / 100ps
// block_coverage_bitmap_checker: watches the item, result and register ports
// of the block coverage bitmap, predicts each result and compares it field by
// field. Depends on bcb_pkg only.
module block_coverage_bitmap_checker
  import bcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  // block_index[14:0], block_count[27:15], start_word[37:28], zero fill
  input  logic [IN_D_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [IN_U_W-1:0]  in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  // status[1:0], is_free[2], blocks_marked[15:3], found_block[30:16],
  // found_word[40:31], zero fill
  input  logic [OUT_D_W-1:0] out_tdata,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output int                 fail_count,
  output int                 outstanding,
  output int                 results_checked,
  output int                 none_seen,
  output int                 range_seen
);

  localparam int WB = WORD_BITS_DEF;
  localparam int MW = MAP_WORDS_DEF;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              is_free;
    logic [CNT_W-1:0]  marked;
    logic [BLK_W-1:0]  found_block;
    logic [SW_W-1:0]   found_word;
  } answer_t;

  logic [WB-1:0]    visit_words [MW];
  logic             stop_on_used;
  logic [CFG_W-1:0] scan_limit;
  logic [CFG_W-1:0] last_allowed;
  answer_t          expected_answers [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one operation to the shadow bitmap and return the answer it gives
  function automatic answer_t apply_bitmap_op(input logic [OP_W-1:0] op,
                                              input logic [BLK_W-1:0] blk,
                                              input logic [CNT_W-1:0] cnt,
                                              input logic [SW_W-1:0] sw);
    answer_t     a;
    int unsigned pos, left, idx, bit_pos, take, marked, first_free;
    logic [63:0] span;
    logic        halt;
    a      = '0;
    marked = 0;
    halt   = 1'b0;
    case (op)
      OP_QUERY: begin
        idx = blk / WB;
        if (idx >= MW) begin
          a.status = STATUS_RANGE;
        end else begin
          a.is_free = ~visit_words[idx][blk % WB];
        end
      end
      OP_MARK: begin
        pos  = blk;
        left = cnt;
        while (left != 0 && !halt) begin
          idx     = pos / WB;
          bit_pos = pos % WB;
          if (idx >= MW) begin
            a.status = STATUS_RANGE;
            halt     = 1'b1;
          end else if (stop_on_used && visit_words[idx][bit_pos]) begin
            if (marked == 0) marked = 1;
            halt = 1'b1;
          end else begin
            take = (left + bit_pos > WB) ? WB - bit_pos : left;
            span = ((64'd1 << take) - 64'd1) << bit_pos;
            visit_words[idx] = visit_words[idx] | span[WB-1:0];
            left   -= take;
            marked += take;
            pos    += take;
          end
        end
        a.marked = marked[CNT_W-1:0];
      end
      OP_FIND: begin
        idx      = sw;
        pos      = sw * WB;
        a.status = STATUS_NONE;
        while (pos < scan_limit && !halt) begin
          if (idx >= MW) begin
            a.status = STATUS_RANGE;
            halt     = 1'b1;
          end else if (visit_words[idx] != '1) begin
            first_free = 0;
            while (visit_words[idx][first_free]) first_free++;
            if (pos + first_free <= last_allowed) begin
              a.status      = STATUS_OK;
              a.found_block = BLK_W'(pos + first_free);
              a.found_word  = SW_W'(idx);
            end
            halt = 1'b1;
          end else begin
            pos += WB;
            idx++;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t got, want;
    if (!rst_n) begin
      for (int w = 0; w < MW; w++) visit_words[w] = '0;
      stop_on_used = 1'b0;
      scan_limit   = SCAN_LIMIT_RST;
      last_allowed = MAX_BLOCK_RST;
      expected_answers.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status      = out_tdata[1:0];
        got.is_free     = out_tdata[2];
        got.marked      = out_tdata[15:3];
        got.found_block = out_tdata[30:16];
        got.found_word  = out_tdata[40:31];
        if (expected_answers.size() == 0) begin
          report("result with nothing expected", out_tdata, '0);
        end else begin
          want = expected_answers.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.is_free !== want.is_free) report("is_free", got.is_free, want.is_free);
          if (got.marked !== want.marked) report("blocks_marked", got.marked, want.marked);
          if (got.found_block !== want.found_block)
            report("found_block", got.found_block, want.found_block);
          if (got.found_word !== want.found_word)
            report("found_word", got.found_word, want.found_word);
          results_checked++;
          if (want.status == STATUS_NONE) none_seen++;
          if (want.status == STATUS_RANGE) range_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_STOP_AT_USED: stop_on_used = cfg_wdata[0];
          REG_SCAN_LIMIT:   scan_limit   = cfg_wdata;
          REG_MAX_BLOCK:    last_allowed = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_answers.push_back(apply_bitmap_op(in_tuser, in_tdata[14:0],
                                                   in_tdata[27:15], in_tdata[37:28]));
      outstanding <= expected_answers.size();
    end
  end

endmodule

>>> tb/block_coverage_bitmap_tb.sv
`timescale 1ns / 100ps
// block_coverage_bitmap_tb: makes query, mark and find-free items for the
// block coverage bitmap under several idling phases and gives the verdict.
// Depends on bcb_pkg, block_coverage_bitmap and block_coverage_bitmap_checker.
module block_coverage_bitmap_tb;
  import bcb_pkg::*;

  // Opcode 3 has no name in the package; it must answer all zeros
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int PHASES          = 4;
  // Cycles with no handshake at all before the run is given up. The slowest
  // legal gap is the clearing sweep or a full-map search plus a long receiver
  // stall, so this leaves a wide margin.
  localparam int QUIET_LIMIT     = 20000;
  // Quiet cycles at the end to catch stray results after the last expected
  localparam int END_GAP         = 100;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_D_W-1:0]  in_tdata;
  logic [IN_U_W-1:0]  in_tuser;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_D_W-1:0] out_tdata;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int sent_query    = 0;
  int sent_mark     = 0;
  int sent_find     = 0;
  int sent_unused   = 0;
  int fail_count, outstanding, results_checked, none_seen, range_seen;

  block_coverage_bitmap DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  block_coverage_bitmap_checker u_bitmap_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .none_seen       (none_seen),
    .range_seen      (range_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drop ready at random, as often as the current phase asks
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one item, idling beforehand as the phase asks, and hold it until
  // the block takes it. Valid stays high on return so that a following item
  // can go out back to back.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                           input logic [CNT_W-1:0] cnt, input logic [SW_W-1:0] sw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, sw, cnt, blk};
    do @(posedge clk); while (!in_tready);
    case (op)
      OP_QUERY: sent_query++;
      OP_MARK:  sent_mark++;
      OP_FIND:  sent_find++;
      default:  sent_unused++;
    endcase
  endtask

  // Hold the sender off until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Rewrite all three registers once the block has gone idle
  task automatic retune(input logic stop, input logic [CFG_W-1:0] scan,
                        input logic [CFG_W-1:0] last_ok);
    drain();
    write_reg(REG_STOP_AT_USED, {15'd0, stop});
    write_reg(REG_SCAN_LIMIT, scan);
    write_reg(REG_MAX_BLOCK, last_ok);
    cfg_we <= 1'b0;
  endtask

  // Random item. Most activity falls in one 2048-block window per phase, so
  // that marks overlap, words fill up and searches have to walk over full
  // words; the rest spreads over the whole map and its top end.
  task automatic send_random_item(input int window);
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
    logic [SW_W-1:0]  sw;
    int               pick;
    int               base;
    base = window * 8192;
    pick = $urandom_range(99);
    op   = (pick < 30) ? OP_QUERY : (pick < 60) ? OP_MARK : (pick < 95) ? OP_FIND : OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 60) blk = BLK_W'(base + $urandom_range(2047));
    else if (pick < 63) blk = BLK_W'($urandom_range(32767, 32700));
    else blk = BLK_W'($urandom);
    // Short runs dominate; a few long ones cross many words or leave the map
    pick = $urandom_range(99);
    if (pick < 75) cnt = CNT_W'($urandom_range(40, 1));
    else if (pick < 92) cnt = CNT_W'($urandom_range(256));
    else if (pick < 97) cnt = CNT_W'($urandom_range(1024));
    else if (pick < 99) cnt = CNT_W'($urandom_range(4096));
    else cnt = CNT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) sw = SW_W'(base / WORD_BITS_DEF + $urandom_range(63));
    else if (pick < 85) sw = SW_W'($urandom);
    else sw = SW_W'($urandom_range(1023, 960));
    send_item(op, blk, cnt, sw);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, registers at their reset values: fresh map, zero count,
    // a run across a word edge, overlap, the unused opcode, the top words
    send_item(OP_QUERY, 15'd0, 13'd0, 10'd0);
    send_item(OP_QUERY, 15'd32767, 13'd0, 10'd0);
    send_item(OP_FIND, 15'd0, 13'd0, 10'd0);
    send_item(OP_MARK, 15'd0, 13'd0, 10'd0);
    send_item(OP_MARK, 15'd0, 13'd40, 10'd0);
    send_item(OP_QUERY, 15'd39, 13'd0, 10'd0);
    send_item(OP_QUERY, 15'd40, 13'd0, 10'd0);
    send_item(OP_FIND, 15'd0, 13'd0, 10'd0);
    send_item(OP_MARK, 15'd5, 13'd32, 10'd0);
    send_item(OP_UNUSED, 15'h7FFF, 13'h1FFF, 10'h3FF);
    send_item(OP_MARK, 15'd32704, 13'd64, 10'd0);
    // Scan stops at the limit, which lies at the map end
    send_item(OP_FIND, 15'd0, 13'd0, 10'd1022);
    // Run falls off the end of the map
    send_item(OP_MARK, 15'd32760, 13'd100, 10'd0);

    // Limit beyond the map: the search leaves it
    retune(1'b0, 16'hFFFF, 16'hFFFF);
    send_item(OP_FIND, 15'd0, 13'd0, 10'd1023);
    send_item(OP_FIND, 15'd0, 13'd0, 10'd1022);

    // Stop at used: at once on a marked block, and part way through a run
    retune(1'b1, 16'hFFFF, 16'hFFFF);
    send_item(OP_MARK, 15'd30, 13'd10, 10'd0);
    send_item(OP_MARK, 15'd64, 13'd50, 10'd0);
    send_item(OP_MARK, 15'd48, 13'd40, 10'd0);
    send_item(OP_MARK, 15'd32767, 13'h1FFF, 10'd0);

    // Found block above the highest allowed block, then an empty scan range
    retune(1'b0, 16'hFFFF, 16'd0);
    send_item(OP_FIND, 15'd0, 13'd0, 10'd0);
    retune(1'b0, 16'd0, 16'hFFFF);
    send_item(OP_FIND, 15'd0, 13'd0, 10'd0);

    // Random part: one register setting and one idling pattern per phase
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: retune(1'b0, 16'hFFFF, 16'hFFFF);
        1: retune(1'b1, CFG_W'($urandom_range(32768, 8192)), CFG_W'($urandom_range(32767, 4096)));
        2: retune(1'b0, SCAN_LIMIT_RST, 16'd32767);
        default: retune(1'b1, CFG_W'($urandom), CFG_W'($urandom));
      endcase
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_item(p);
    end

    drain();
    repeat (END_GAP) @(posedge clk);
    $display("Sent %0d queries, %0d marks, %0d searches, %0d unused opcodes in four phases.",
             sent_query, sent_mark, sent_find, sent_unused);
    $display("Compared %0d results: %0d with no free block, %0d out of range.",
             results_checked, none_seen, range_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bcb_pkg.sv
hw/rtl/block_coverage_bitmap.sv
tb/block_coverage_bitmap_checker.sv
tb/block_coverage_bitmap_tb.sv
